/* rtl/lcrq_pkg.sv */
// lcrq_pkg: shared types and constants for the latency countdown request queue
// used by lcrq_cell and latency_countdown_request_queue_unit; no dependencies
package lcrq_pkg;

    // countdown width of one queue entry
    localparam int LAT_WIDTH = 8;

    // configuration port widths
    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 8;

    // configuration register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_NORMAL_LATENCY = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FILL_LATENCY   = 8'd1;

    // request mode codes
    localparam logic MODE_TICK   = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    // result kind codes
    localparam logic KIND_RELEASE = 1'b0;
    localparam logic KIND_DROP    = 1'b1;

    // latency value that expires on the next tick
    localparam logic [LAT_WIDTH-1:0] LAT_DUE = 8'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_TICK,
        ST_FLUSH
    } state_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

/* rtl/lcrq_cell.sv */
// lcrq_cell: one queue slot holding valid, countdown and tag
// takes its neighbor's contents on shift or the broadcast entry on load; uses lcrq_pkg
module lcrq_cell #(
    parameter int TAG_WIDTH = 32
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  lcrq_pkg::cell_ctl_t            ctl,
    input  logic                           nb_valid,
    input  logic [lcrq_pkg::LAT_WIDTH-1:0] nb_rem,
    input  logic [TAG_WIDTH-1:0]           nb_tag,
    input  logic [lcrq_pkg::LAT_WIDTH-1:0] ld_rem,
    input  logic [TAG_WIDTH-1:0]           ld_tag,
    output logic                           valid,
    output logic [lcrq_pkg::LAT_WIDTH-1:0] rem,
    output logic [TAG_WIDTH-1:0]           tag
);

    logic                           valid_reg;
    logic [lcrq_pkg::LAT_WIDTH-1:0] rem_reg;
    logic [TAG_WIDTH-1:0]           tag_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ctl.load) begin
            valid_reg <= 1'b1;
        end else if (ctl.shift) begin
            valid_reg <= nb_valid;
        end
    end

    // payload has no reset
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            rem_reg <= ld_rem;
            tag_reg <= ld_tag;
        end else if (ctl.shift) begin
            rem_reg <= nb_rem;
            tag_reg <= nb_tag;
        end
    end

    assign valid = valid_reg;
    assign rem   = rem_reg;
    assign tag   = tag_reg;

endmodule

/* rtl/latency_countdown_request_queue_unit.sv */
// latency_countdown_request_queue_unit: top level of the countdown request queue
// a row of lcrq_cell slots shifting toward the head, plus sequencer; uses lcrq_pkg
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+----------------------------------------
//   s_      | in  | s_tvalid/s_tready  | tuser: mode, is_fill; tdata: request_tag
//   m_      | out | m_tvalid/m_tready  | tuser: kind; tdata: released_tag; tlast
//   cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// an insert request completes on acceptance, or goes on to a flush when it is dropped;
// a tick request is accepted, examines the head cell once per held entry, closes the
// pass and ends with a flush
// the head of the cell row is examined once per cycle; a release stalls while the
// output register is full and not taken while an earlier result is held
// each release waits in the one-deep hold so the last release of a tick carries tlast
// reset (aresetn low, synchronous) empties the queue, latencies return to one
module latency_countdown_request_queue_unit #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_WIDTH   = 32
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // request input
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [((TAG_WIDTH+7)/8)*8-1:0]       s_tdata,   // [TAG_WIDTH-1:0] request_tag
    input  logic [1:0]                           s_tuser,   // [0] mode, [1] is_fill
    // result output
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [((TAG_WIDTH+7)/8)*8-1:0]       m_tdata,   // [TAG_WIDTH-1:0] released_tag
    output logic                                 m_tuser,   // [0] kind
    output logic                                 m_tlast,
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lcrq_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [lcrq_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

    localparam int TDATA_W = ((TAG_WIDTH + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W   = $clog2(QUEUE_DEPTH);
    localparam int LAT_W   = lcrq_pkg::LAT_WIDTH;

    // sequencer state
    lcrq_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;     // entries held
    logic [CNT_W-1:0] pass_reg, pass_next;       // entries still to examine in a tick

    // one-deep hold for the latest release or drop
    logic                 pend_valid_reg, pend_valid_next;
    logic                 pend_kind_reg, pend_kind_next;
    logic [TAG_WIDTH-1:0] pend_tag_reg, pend_tag_next;

    // output register
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 m_kind_reg, m_kind_next;
    logic [TAG_WIDTH-1:0] m_tag_reg, m_tag_next;
    logic                 m_last_reg, m_last_next;

    // latency registers
    logic [LAT_W-1:0] normal_lat_reg, normal_lat_next;
    logic [LAT_W-1:0] fill_lat_reg, fill_lat_next;

    // cell row
    logic [QUEUE_DEPTH-1:0] cell_valid;
    logic [LAT_W-1:0]       cell_rem [QUEUE_DEPTH];
    logic [TAG_WIDTH-1:0]   cell_tag [QUEUE_DEPTH];

    // broadcast load into one cell
    logic                 row_shift;
    logic                 row_load;
    logic [IDX_W-1:0]     ld_idx;
    logic [LAT_W-1:0]     ld_rem;
    logic [TAG_WIDTH-1:0] ld_tag;

    // decoded request and head status
    logic                 s_accept;
    logic                 in_insert;
    logic                 in_fill;
    logic [TAG_WIDTH-1:0] in_tag;
    logic                 full;
    logic                 out_free;
    logic                 head_due;
    logic [LAT_W-1:0]     head_rem_dec;
    logic                 step;
    logic [CNT_W-1:0]     count_dec;

    assign s_tready  = (state_reg == lcrq_pkg::ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign in_insert = (s_tuser[0] == lcrq_pkg::MODE_INSERT);
    assign in_fill   = s_tuser[1];
    assign in_tag    = s_tdata[TAG_WIDTH-1:0];

    assign full         = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign count_dec    = count_reg - CNT_W'(1);
    assign out_free     = !m_tvalid_reg || m_tready;
    // head expires when its countdown is one; zero wraps to 255 and counts down from there
    assign head_due     = (cell_rem[0] == lcrq_pkg::LAT_DUE);
    assign head_rem_dec = cell_rem[0] - LAT_W'(1);
    // a release must be able to push the held one out first
    assign step = (state_reg == lcrq_pkg::ST_TICK) && (pass_reg != '0)
                  && (!head_due || !pend_valid_reg || out_free);

    // cell row: each cell takes its upper neighbor on shift
    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
            lcrq_pkg::cell_ctl_t  ctl;
            logic                 nb_valid;
            logic [LAT_W-1:0]     nb_rem;
            logic [TAG_WIDTH-1:0] nb_tag;

            assign ctl.shift = row_shift;
            assign ctl.load  = row_load && (ld_idx == IDX_W'(gi));

            if (gi < QUEUE_DEPTH - 1) begin : g_mid
                assign nb_valid = cell_valid[gi+1];
                assign nb_rem   = cell_rem[gi+1];
                assign nb_tag   = cell_tag[gi+1];
            end else begin : g_tail
                assign nb_valid = 1'b0;
                assign nb_rem   = '0;
                assign nb_tag   = '0;
            end

            lcrq_cell #(
                .TAG_WIDTH(TAG_WIDTH)
            ) u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctl     (ctl),
                .nb_valid(nb_valid),
                .nb_rem  (nb_rem),
                .nb_tag  (nb_tag),
                .ld_rem  (ld_rem),
                .ld_tag  (ld_tag),
                .valid   (cell_valid[gi]),
                .rem     (cell_rem[gi]),
                .tag     (cell_tag[gi])
            );
        end
    endgenerate

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            lcrq_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (!in_insert) begin
                        state_next = lcrq_pkg::ST_TICK;
                    end else if (full) begin
                        state_next = lcrq_pkg::ST_FLUSH;
                    end
                end
            end
            lcrq_pkg::ST_TICK: begin
                if (pass_reg == '0) begin
                    state_next = lcrq_pkg::ST_FLUSH;
                end
            end
            lcrq_pkg::ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = lcrq_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lcrq_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath controls and register next values
    always_comb begin
        count_next      = count_reg;
        pass_next       = pass_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_tag_next   = pend_tag_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_kind_next     = m_kind_reg;
        m_tag_next      = m_tag_reg;
        m_last_next     = m_last_reg;
        row_shift       = 1'b0;
        row_load        = 1'b0;
        ld_idx          = count_reg[IDX_W-1:0];
        ld_rem          = in_fill ? fill_lat_reg : normal_lat_reg;
        ld_tag          = in_tag;

        case (state_reg)
            lcrq_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (!in_insert) begin
                        pass_next = count_reg;
                    end else if (full) begin
                        // dropped insert goes out alone, marked last
                        pend_valid_next = 1'b1;
                        pend_kind_next  = lcrq_pkg::KIND_DROP;
                        pend_tag_next   = in_tag;
                    end else begin
                        row_load   = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
            end
            lcrq_pkg::ST_TICK: begin
                if (step) begin
                    row_shift = 1'b1;
                    pass_next = pass_reg - CNT_W'(1);
                    if (head_due) begin
                        if (pend_valid_reg) begin
                            m_tvalid_next = 1'b1;
                            m_kind_next   = pend_kind_reg;
                            m_tag_next    = pend_tag_reg;
                            m_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_kind_next  = lcrq_pkg::KIND_RELEASE;
                        pend_tag_next   = cell_tag[0];
                        count_next      = count_dec;
                    end else begin
                        // kept entry rejoins at the tail, order preserved
                        row_load = 1'b1;
                        ld_idx   = count_dec[IDX_W-1:0];
                        ld_rem   = head_rem_dec;
                        ld_tag   = cell_tag[0];
                    end
                end
            end
            lcrq_pkg::ST_FLUSH: begin
                if (pend_valid_reg && out_free) begin
                    m_tvalid_next   = 1'b1;
                    m_kind_next     = pend_kind_reg;
                    m_tag_next      = pend_tag_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // configuration writes, always ready
    assign cfg_ready = 1'b1;

    always_comb begin
        normal_lat_next = normal_lat_reg;
        fill_lat_next   = fill_lat_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                lcrq_pkg::CFG_NORMAL_LATENCY: normal_lat_next = cfg_data[LAT_W-1:0];
                lcrq_pkg::CFG_FILL_LATENCY:   fill_lat_next   = cfg_data[LAT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= lcrq_pkg::ST_IDLE;
            count_reg      <= '0;
            pass_reg       <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            normal_lat_reg <= LAT_W'(1);
            fill_lat_reg   <= LAT_W'(1);
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pass_reg       <= pass_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            normal_lat_reg <= normal_lat_next;
            fill_lat_reg   <= fill_lat_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        pend_kind_reg <= pend_kind_next;
        pend_tag_reg  <= pend_tag_next;
        m_kind_reg    <= m_kind_next;
        m_tag_reg     <= m_tag_next;
        m_last_reg    <= m_last_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(m_tag_reg);
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

    // occupied cells always match the fill count
    a_valid_count: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(cell_valid) == count_reg)
        else $error("cell valid bits disagree with fill count");

    // nothing may be held back while idle
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lcrq_pkg::ST_IDLE |-> !pend_valid_reg)
        else $error("held result left behind in idle");

    // a tick pass never examines more entries than are held
    a_pass_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == lcrq_pkg::ST_TICK |-> pass_reg <= count_reg)
        else $error("tick pass exceeds fill count");

    // a dropped insert is always the only and last result of its request
    a_drop_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_kind_reg == lcrq_pkg::KIND_DROP |-> m_last_reg)
        else $error("drop result without last");

endmodule
